// File: rtl/gesl_pkg.sv
// ---------------------------------------------------------------------------
// gesl_pkg: shared types and constants of the Gaussian elimination solver
// Command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package gesl_pkg;

    localparam int DATA_W            = 32;  // Q-format word
    localparam int IDX_W             = 3;   // unknown_index width
    localparam int CFG_FIELD_W       = 4;   // unknown_count register width
    localparam int APB_AW            = 3;   // byte address of one 32-bit register
    localparam int APB_DW            = 32;
    localparam int RESET_COUNT       = 3;
    localparam int REG_UNKNOWN_COUNT = 0;   // register index

    typedef struct packed {
        logic mem_we;      // write matrix store
        logic wsel_sub;    // matrix write data: 1 = difference, 0 = coefficient
        logic opa_mem;     // opa <= matrix read data
        logic opa_sub;     // opa <= saturated difference
        logic opb_mem;     // opb <= matrix read data
        logic opb_sol;     // opb <= solution read data
        logic ratio_mem;   // ratio <= matrix read data
        logic ratio_quot;  // ratio <= divider quotient
        logic mul;         // product <= ratio * opb
        logic rnd;         // rounded product <= round/saturate(product)
        logic div_start;   // divide opa by opb
        logic sol_we;      // solution store <= divider quotient
        logic out_ld;      // load result register
        logic out_err;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic opb_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/gesl_ram.sv
// ---------------------------------------------------------------------------
// gesl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gesl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gesl_div.sv
// ---------------------------------------------------------------------------
// gesl_div: sequential fixed-point divider
// (a << FRACTION_BITS) / b, truncated toward zero, saturated to 32 bits.
// One quotient bit per cycle over magnitudes, then a sign/saturation step.
// ---------------------------------------------------------------------------
module gesl_div
    import gesl_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int NB    = DATA_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NB + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NB-1:0]    r_num;
    logic [DATA_W:0]  r_rem;
    logic [DATA_W-1:0] r_den, r_quot;
    logic             r_neg;

    logic [DATA_W-1:0] a_mag, b_mag;
    logic [DATA_W:0]   trial;
    logic              ge;
    logic              sat_pos, sat_neg;

    assign a_mag = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign b_mag = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign trial = {r_rem[DATA_W-1:0], r_num[NB-1]};
    assign ge    = (trial >= {1'b0, r_den});

    // quotient magnitude is complete in r_num when the count hits zero
    assign sat_pos = |r_num[NB-1:DATA_W-1];
    assign sat_neg = (|r_num[NB-1:DATA_W]) ||
                     (r_num[DATA_W-1] && (|r_num[DATA_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NB);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {a_mag, {FRACTION_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= b_mag;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy && (r_cnt != '0)) begin
            r_num <= {r_num[NB-2:0], ge};
            r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
        end else if (r_busy) begin
            if (!r_neg) begin
                r_quot <= sat_pos ? {1'b0, {(DATA_W-1){1'b1}}} : r_num[DATA_W-1:0];
            end else begin
                r_quot <= sat_neg ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : (~r_num[DATA_W-1:0] + 1'b1);
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// File: rtl/gesl_datapath.sv
// ---------------------------------------------------------------------------
// gesl_datapath: storage and arithmetic of the solver
// Matrix and solution stores, multiply/round/subtract chain, divider and
// the result register.
// ---------------------------------------------------------------------------
module gesl_datapath
    import gesl_pkg::*;
#(
    parameter int MAX_UNKNOWNS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  t_dp_cmd                                      i_cmd,
    output t_dp_sts                                      o_sts,
    input  logic [DATA_W-1:0]                            i_coefficient,
    input  logic [$clog2(MAX_UNKNOWNS*(MAX_UNKNOWNS+1))-1:0] i_mem_addr,
    input  logic [$clog2(MAX_UNKNOWNS)-1:0]              i_sol_waddr,
    input  logic [$clog2(MAX_UNKNOWNS)-1:0]              i_sol_raddr,
    input  logic [IDX_W-1:0]                             i_out_idx,
    input  logic                                         i_result_stall,
    output logic                                         o_result_valid,
    output logic signed [DATA_W-1:0]                     o_solution_value,
    output logic [IDX_W-1:0]                             o_unknown_index,
    output logic                                         o_zero_pivot_error,
    output logic                                         o_last_result
);

    localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
    localparam logic signed [2*DATA_W-1:0] HALF = (2*DATA_W)'(1) << (FRACTION_BITS - 1);
    localparam logic signed [2*DATA_W-1:0] WMAX = (2*DATA_W)'(32'h7fff_ffff);
    localparam logic signed [2*DATA_W-1:0] WMIN = -((2*DATA_W)'(32'h7fff_ffff)) - 1;

    logic [DATA_W-1:0] mem_rdata, mem_wdata, sol_rdata, quot;
    logic signed [DATA_W-1:0] r_opa, r_opb, r_ratio, r_prod;
    logic signed [2*DATA_W-1:0] r_mprod, rsum, rsh;
    logic signed [DATA_W:0] diff;
    logic signed [DATA_W-1:0] sub_sat, rnd_sat;
    logic div_busy, div_done;

    logic r_out_valid;
    logic [DATA_W-1:0] r_out_val;
    logic [IDX_W-1:0]  r_out_idx;
    logic r_out_err, r_out_last;

    gesl_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (i_mem_addr),
        .i_wdata (mem_wdata),
        .i_raddr (i_mem_addr),
        .o_rdata (mem_rdata)
    );

    gesl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS)) u_sol (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sol_we),
        .i_waddr (i_sol_waddr),
        .i_wdata (quot),
        .i_raddr (i_sol_raddr),
        .o_rdata (sol_rdata)
    );

    gesl_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_opa),
        .i_divisor  (r_opb),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // round half up: add half an LSB, floor shift, saturate
    always_comb begin
        rsum = r_mprod + HALF;
        rsh  = rsum >>> FRACTION_BITS;
        if (rsh > WMAX) begin
            rnd_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (rsh < WMIN) begin
            rnd_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            rnd_sat = rsh[DATA_W-1:0];
        end
    end

    always_comb begin
        diff = {r_opa[DATA_W-1], r_opa} - {r_prod[DATA_W-1], r_prod};
        if (diff[DATA_W] != diff[DATA_W-1]) begin
            sub_sat = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sub_sat = diff[DATA_W-1:0];
        end
    end

    assign mem_wdata = i_cmd.wsel_sub ? sub_sat : i_coefficient;

    always_ff @(posedge i_clk) begin
        if (i_cmd.opa_mem) begin
            r_opa <= mem_rdata;
        end else if (i_cmd.opa_sub) begin
            r_opa <= sub_sat;
        end
        if (i_cmd.opb_mem) begin
            r_opb <= mem_rdata;
        end else if (i_cmd.opb_sol) begin
            r_opb <= sol_rdata;
        end
        if (i_cmd.ratio_mem) begin
            r_ratio <= mem_rdata;
        end else if (i_cmd.ratio_quot) begin
            r_ratio <= quot;
        end
        if (i_cmd.mul) begin
            r_mprod <= r_ratio * r_opb;
        end
        if (i_cmd.rnd) begin
            r_prod <= rnd_sat;
        end
        if (i_cmd.out_ld) begin
            r_out_val  <= i_cmd.out_err ? '0 : sol_rdata;
            r_out_idx  <= i_cmd.out_err ? '0 : i_out_idx;
            r_out_err  <= i_cmd.out_err;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.opb_zero = (r_opb == '0);
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || !i_result_stall;

    assign o_result_valid     = r_out_valid;
    assign o_solution_value   = r_out_val;
    assign o_unknown_index    = r_out_idx;
    assign o_zero_pivot_error = r_out_err;
    assign o_last_result      = r_out_last;

endmodule

// File: rtl/gesl_ctrl.sv
// ---------------------------------------------------------------------------
// gesl_ctrl: solver sequencer
// Load counter, configuration register and the elimination / back
// substitution / emit state machine.
// ---------------------------------------------------------------------------
module gesl_ctrl
    import gesl_pkg::*;
#(
    parameter int MAX_UNKNOWNS = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic [CFG_FIELD_W-1:0]                       i_cfg_value,
    output logic [APB_DW-1:0]                            o_cfg_rdata,
    input  logic                                         i_coefficient_valid,
    output logic                                         o_coefficient_stall,
    output t_dp_cmd                                      o_cmd,
    input  t_dp_sts                                      i_sts,
    output logic [$clog2(MAX_UNKNOWNS*(MAX_UNKNOWNS+1))-1:0] o_mem_addr,
    output logic [$clog2(MAX_UNKNOWNS)-1:0]              o_sol_waddr,
    output logic [$clog2(MAX_UNKNOWNS)-1:0]              o_sol_raddr,
    output logic [IDX_W-1:0]                             o_out_idx
);

    localparam int CW = $clog2(MAX_UNKNOWNS + 1);
    localparam int AW = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1));
    localparam int SW = $clog2(MAX_UNKNOWNS);
    localparam int NS = 27;

    typedef enum logic [NS-1:0] {
        S_LOAD    = NS'(1) << 0,
        S_PIV_RD  = NS'(1) << 1,
        S_PIV_LT  = NS'(1) << 2,
        S_PIV_CHK = NS'(1) << 3,
        S_EJ_RD   = NS'(1) << 4,
        S_EJ_LT   = NS'(1) << 5,
        S_DIV     = NS'(1) << 6,
        S_DIV_WT  = NS'(1) << 7,
        S_K_RDI   = NS'(1) << 8,
        S_K_RDJ   = NS'(1) << 9,
        S_K_MUL   = NS'(1) << 10,
        S_K_RND   = NS'(1) << 11,
        S_K_WR    = NS'(1) << 12,
        S_B_RDN   = NS'(1) << 13,
        S_B_LTN   = NS'(1) << 14,
        S_B_RDJ   = NS'(1) << 15,
        S_B_LTJ   = NS'(1) << 16,
        S_B_MUL   = NS'(1) << 17,
        S_B_RND   = NS'(1) << 18,
        S_B_SUB   = NS'(1) << 19,
        S_B_RDD   = NS'(1) << 20,
        S_B_LTD   = NS'(1) << 21,
        S_B_DIV   = NS'(1) << 22,
        S_B_DWT   = NS'(1) << 23,
        S_E_RD    = NS'(1) << 24,
        S_E_OUT   = NS'(1) << 25,
        S_ERR     = NS'(1) << 26
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, r_i, n_i, r_j, n_j, r_k, n_k, r_e, n_e;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] row, col;
    logic [CW:0]   width;
    logic [2*CW:0] row_base;
    logic [AW:0]   total;
    logic          accept;

    assign width    = {1'b0, r_count} + 1'b1;
    assign total    = (AW+1)'(r_count * width);
    assign row_base = row * width;
    assign accept   = i_coefficient_valid && (r_state == S_LOAD);

    assign o_coefficient_stall = (r_state != S_LOAD);
    assign o_cfg_rdata         = APB_DW'(r_count);
    assign o_sol_waddr         = r_i[SW-1:0];
    assign o_out_idx           = IDX_W'(r_e);

    always_comb begin
        case (r_state)
            S_EJ_RD:                  begin row = r_j; col = r_i; end
            S_K_RDI:                  begin row = r_i; col = r_k; end
            S_K_RDJ, S_K_WR:          begin row = r_j; col = r_k; end
            S_B_RDN:                  begin row = r_i; col = r_count; end
            S_B_RDJ:                  begin row = r_i; col = r_j; end
            default:                  begin row = r_i; col = r_i; end
        endcase
        if (r_state == S_LOAD) begin
            o_mem_addr = r_pos;
        end else begin
            o_mem_addr = AW'(row_base + (2*CW+1)'(col));
        end
        o_sol_raddr = (r_state == S_B_RDJ) ? r_j[SW-1:0] : r_e[SW-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_e     = r_e;
        n_pos   = r_pos;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    o_cmd.mem_we = 1'b1;
                    if (({1'b0, r_pos} + 1'b1) == total) begin
                        n_pos   = '0;
                        n_i     = '0;
                        n_j     = CW'(1);
                        n_state = S_PIV_RD;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            S_PIV_RD: n_state = S_PIV_LT;
            S_PIV_LT: begin
                o_cmd.opb_mem = 1'b1;
                n_state       = S_PIV_CHK;
            end
            S_PIV_CHK: begin
                if (i_sts.opb_zero) begin
                    n_state = S_ERR;
                end else if (r_j < r_count) begin
                    n_state = S_EJ_RD;
                end else if ((r_i + 1'b1) < r_count) begin
                    n_i     = r_i + 1'b1;
                    n_j     = r_i + CW'(2);
                    n_state = S_PIV_RD;
                end else begin
                    n_i     = r_count - 1'b1;
                    n_state = S_B_RDN;
                end
            end
            S_EJ_RD: n_state = S_EJ_LT;
            S_EJ_LT: begin
                o_cmd.opa_mem = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WT;
            end
            S_DIV_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.ratio_quot = 1'b1;
                    n_k              = r_i;
                    n_state          = S_K_RDI;
                end
            end
            S_K_RDI: n_state = S_K_RDJ;
            S_K_RDJ: begin
                o_cmd.opb_mem = 1'b1;
                n_state       = S_K_MUL;
            end
            S_K_MUL: begin
                o_cmd.opa_mem = 1'b1;
                o_cmd.mul     = 1'b1;
                n_state       = S_K_RND;
            end
            S_K_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_K_WR;
            end
            S_K_WR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.wsel_sub = 1'b1;
                if (r_k == r_count) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_PIV_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_K_RDI;
                end
            end
            S_B_RDN: n_state = S_B_LTN;
            S_B_LTN: begin
                o_cmd.opa_mem = 1'b1;
                n_j           = r_i + 1'b1;
                n_state       = ((r_i + 1'b1) < r_count) ? S_B_RDJ : S_B_RDD;
            end
            S_B_RDJ: n_state = S_B_LTJ;
            S_B_LTJ: begin
                o_cmd.ratio_mem = 1'b1;
                o_cmd.opb_sol   = 1'b1;
                n_state         = S_B_MUL;
            end
            S_B_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_B_RND;
            end
            S_B_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_B_SUB;
            end
            S_B_SUB: begin
                o_cmd.opa_sub = 1'b1;
                n_j           = r_j + 1'b1;
                n_state       = ((r_j + 1'b1) < r_count) ? S_B_RDJ : S_B_RDD;
            end
            S_B_RDD: n_state = S_B_LTD;
            S_B_LTD: begin
                o_cmd.opb_mem = 1'b1;
                n_state       = S_B_DIV;
            end
            S_B_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_B_DWT;
            end
            S_B_DWT: begin
                if (i_sts.div_done) begin
                    o_cmd.sol_we = 1'b1;
                    if (r_i == '0) begin
                        n_e     = '0;
                        n_state = S_E_RD;
                    end else begin
                        n_i     = r_i - 1'b1;
                        n_state = S_B_RDN;
                    end
                end
            end
            S_E_RD: n_state = S_E_OUT;
            S_E_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_last = ((r_e + 1'b1) == r_count);
                    if ((r_e + 1'b1) == r_count) begin
                        n_state = S_LOAD;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_state = S_E_RD;
                    end
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
        if (i_cfg_we) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= CW'(RESET_COUNT);
            r_pos   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_e     <= n_e;
            if (i_cfg_we) begin
                if (i_cfg_value == '0) begin
                    r_count <= CW'(1);
                end else if (int'(i_cfg_value) > MAX_UNKNOWNS) begin
                    r_count <= CW'(MAX_UNKNOWNS);
                end else begin
                    r_count <= CW'(i_cfg_value);
                end
            end
        end
    end

endmodule

// File: rtl/gaussian_elimination_solver.sv
// ---------------------------------------------------------------------------
// gaussian_elimination_solver: fixed-point n-by-n linear system solver
// Loads an augmented matrix, eliminates, back-substitutes, emits unknowns.
// ---------------------------------------------------------------------------
// The augmented matrix (n rows of n+1 signed Q16.16 entries, row-major) is
// streamed in on the coefficient channel, one transfer per cycle, n(n+1)
// transfers per system. After the last entry the input stalls while the
// sequencer runs forward elimination (no pivoting) and back substitution
// over a single-ported matrix RAM, one operand per cycle. Each ratio and
// each unknown comes from a bit-serial divider, which sets most of the
// solve time. The n unknowns then leave in index order on the result
// channel, the last marked with last_result. A zero pivot (any diagonal
// entry, the final one included) produces a single error transfer
// instead (value 0, index 0, zero_pivot_error and last_result set).
// Products round half up, quotients truncate toward zero, and products,
// quotients and differences saturate. unknown_count sits at byte
// address 0 of the APB port; values of 0 read back as 1 and values above
// MAX_UNKNOWNS as MAX_UNKNOWNS. Writing it drops any partial load. A new
// load may start while the final result still waits on the output
// register.
// ---------------------------------------------------------------------------
module gaussian_elimination_solver
    import gesl_pkg::*;
#(
    parameter int MAX_UNKNOWNS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    // coefficient input
    input  logic                     i_coefficient_valid,
    output logic                     o_coefficient_stall,
    input  logic signed [DATA_W-1:0] i_coefficient,
    // result output
    output logic                     o_result_valid,
    input  logic                     i_result_stall,
    output logic signed [DATA_W-1:0] o_solution_value,
    output logic [IDX_W-1:0]         o_unknown_index,
    output logic                     o_zero_pivot_error,
    output logic                     o_last_result
);

    localparam int AW = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1));
    localparam int SW = $clog2(MAX_UNKNOWNS);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [AW-1:0]     mem_addr;
    logic [SW-1:0]     sol_waddr, sol_raddr;
    logic [IDX_W-1:0]  out_idx;
    logic              cfg_we;

    assign pready = 1'b1;
    // register index is the word address; only unknown_count exists
    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr[2] == 1'(REG_UNKNOWN_COUNT));

    gesl_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_value         (pwdata[CFG_FIELD_W-1:0]),
        .o_cfg_rdata         (prdata),
        .i_coefficient_valid (i_coefficient_valid),
        .o_coefficient_stall (o_coefficient_stall),
        .o_cmd               (cmd),
        .i_sts               (sts),
        .o_mem_addr          (mem_addr),
        .o_sol_waddr         (sol_waddr),
        .o_sol_raddr         (sol_raddr),
        .o_out_idx           (out_idx)
    );

    gesl_datapath #(
        .MAX_UNKNOWNS  (MAX_UNKNOWNS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_coefficient      (i_coefficient),
        .i_mem_addr         (mem_addr),
        .i_sol_waddr        (sol_waddr),
        .i_sol_raddr        (sol_raddr),
        .i_out_idx          (out_idx),
        .i_result_stall     (i_result_stall),
        .o_result_valid     (o_result_valid),
        .o_solution_value   (o_solution_value),
        .o_unknown_index    (o_unknown_index),
        .o_zero_pivot_error (o_zero_pivot_error),
        .o_last_result      (o_last_result)
    );

    // an error result is the only and final one, with cleared payload
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_zero_pivot_error) |->
            (o_last_result && (o_solution_value == '0) && (o_unknown_index == '0)))
        else $error("error result malformed");

    // the final good result carries index n-1
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_result && !o_zero_pivot_error) |->
            (o_unknown_index == IDX_W'(prdata - 1)))
        else $error("last result index mismatch");

    // the divider is never restarted mid-division
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // the result register is never overwritten while still held
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |-> (!o_result_valid || !i_result_stall))
        else $error("result overwritten while stalled");

endmodule
